>>> rtl/core/rdd_pkg.sv
// Shared types and constants for the resource deadlock detector.
// No dependencies.
package rdd_pkg;

    // Opcodes of an input transaction
    localparam logic [1:0] OP_LOAD_AVAIL = 2'd0;
    localparam logic [1:0] OP_LOAD_ALLOC = 2'd1;
    localparam logic [1:0] OP_LOAD_REQ   = 2'd2;
    localparam logic [1:0] OP_RUN        = 2'd3;

    // Work entries saturate at this width's maximum
    localparam int unsigned WORK_BITS = 12;
    localparam int unsigned WORK_MAX  = (1 << WORK_BITS) - 1;

    typedef struct packed {
        logic [1:0] operation;
        logic [2:0] process_index;
        logic [1:0] resource_index;
        logic [7:0] amount;
    } t_in_item;

    typedef struct packed {
        logic [2:0] process_id;
        logic       deadlocked;
        logic       last_result;
    } t_out_item;

endpackage

>>> rtl/core/resource_deadlock_detector.sv
// A load transaction is written when accepted. A run takes P passes over the
// allocation and request matrices, P <= NUM_PROCESSES + 1, each paced by the
// single read port of the allocation and request memories (one matrix element
// per cycle), then emits one result per cycle unless the output is stalled.
// Loads are taken one per cycle while idle or emitting; one run at a time.
// Reset (synchronous, active low) clears control, work, available and flags.
module resource_deadlock_detector
    import rdd_pkg::*;
#(
    parameter int NUM_PROCESSES = 8,
    parameter int NUM_RESOURCES = 4,
    parameter int AMOUNT_BITS   = 8
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    // Index widths; the matrices are addressed as {process, resource}
    localparam int PW     = (NUM_PROCESSES > 1) ? $clog2(NUM_PROCESSES) : 1;
    localparam int RW     = (NUM_RESOURCES > 1) ? $clog2(NUM_RESOURCES) : 1;
    localparam int AW     = PW + RW;
    localparam int ADEPTH = NUM_PROCESSES << RW;
    localparam int AB     = AMOUNT_BITS;
    // Work must hold a copied available entry as well as a saturated sum
    localparam int WB     = (AB > WORK_BITS) ? AB : WORK_BITS;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_SETTLE = 2'd2;
    localparam logic [1:0] ST_EMIT   = 2'd3;

    logic [1:0] r_state, n_state;

    // Matrices: one synchronous memory each, same address for both reads
    logic [AB-1:0] mem_alloc [ADEPTH];
    logic [AB-1:0] mem_req   [ADEPTH];
    logic [AB-1:0] r_alloc_q, r_req_q;

    logic [AB-1:0] r_avail [NUM_RESOURCES];
    logic [WB-1:0] r_work  [NUM_RESOURCES];
    logic [WB-1:0] r_tmp   [NUM_RESOURCES];
    logic [NUM_PROCESSES-1:0] r_fin;

    // Scan issue counters and the registered compare stage that trails them
    logic [PW-1:0] r_sp;
    logic [RW-1:0] r_sr;
    logic          r_rd_vld;
    logic [PW-1:0] r_rd_p;
    logic [RW-1:0] r_rd_r;
    logic          r_ok;
    logic          r_changed;

    logic [PW-1:0] r_emit_p;
    logic          r_out_vld;
    t_out_item     r_out;

    // ------------------------------------------------------------------
    // Input decode
    // ------------------------------------------------------------------
    logic          in_acc;
    logic          is_run;
    logic          pi_ok, ri_ok;
    logic [PW+2:0] pi_ext;
    logic [RW+1:0] ri_ext;
    logic [AB+7:0] amt_ext;
    logic [PW-1:0] pi_idx;
    logic [RW-1:0] ri_idx;
    logic [AB-1:0] amt;
    logic [AW-1:0] wr_addr;

    assign is_run  = (i_in_item.operation == OP_RUN);
    // Loads are also taken while results drain: they cannot disturb them
    assign o_in_stall = !((r_state == ST_IDLE) || ((r_state == ST_EMIT) && !is_run));
    assign in_acc  = i_in_valid && !o_in_stall;

    assign pi_ext  = {{PW{1'b0}}, i_in_item.process_index};
    assign ri_ext  = {{RW{1'b0}}, i_in_item.resource_index};
    assign amt_ext = {{AB{1'b0}}, i_in_item.amount};
    assign pi_idx  = pi_ext[PW-1:0];
    assign ri_idx  = ri_ext[RW-1:0];
    assign amt     = amt_ext[AB-1:0];
    assign pi_ok   = (7'(i_in_item.process_index) < 7'(NUM_PROCESSES));
    assign ri_ok   = (5'(i_in_item.resource_index) < 5'(NUM_RESOURCES));
    assign wr_addr = {pi_idx, ri_idx};

    // ------------------------------------------------------------------
    // Compare stage: one request/allocation element per cycle
    // ------------------------------------------------------------------
    logic [WB-1:0] work_sel;
    logic [WB:0]   sum;
    logic [WB-1:0] sat;
    logic          ok_now;
    logic          last_col;
    logic          commit;

    assign work_sel = r_work[r_rd_r];
    assign sum      = (WB+1)'(work_sel) + (WB+1)'(r_alloc_q);
    assign sat      = (sum > (WB+1)'(WORK_MAX)) ? WB'(WORK_MAX) : sum[WB-1:0];
    // Restart the all-requests-fit flag on the first column of each row
    assign ok_now   = ((r_rd_r == '0) ? 1'b1 : r_ok) && (WB'(r_req_q) <= work_sel);
    assign last_col = (r_rd_r == RW'(NUM_RESOURCES - 1));
    // Release the row only once every column has passed
    assign commit   = r_rd_vld && last_col && ok_now && !r_fin[r_rd_p];

    logic scan_last;
    logic out_free;
    logic restart;

    assign scan_last = (r_sp == PW'(NUM_PROCESSES - 1)) && (r_sr == RW'(NUM_RESOURCES - 1));
    assign out_free  = !r_out_vld || !i_out_stall;
    // Another pass is due if any row finished in this one
    assign restart   = (r_state == ST_SETTLE) && (r_changed || commit);

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc && is_run) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (scan_last) begin
                    n_state = ST_SETTLE;
                end
            end
            ST_SETTLE: begin
                n_state = restart ? ST_SCAN : ST_EMIT;
            end
            ST_EMIT: begin
                if (out_free && (r_emit_p == PW'(NUM_PROCESSES - 1))) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Memories: write on a load, read during the scan
    always_ff @(posedge i_clk) begin
        if (in_acc && pi_ok && ri_ok) begin
            if (i_in_item.operation == OP_LOAD_ALLOC) begin
                mem_alloc[wr_addr] <= amt;
            end
            if (i_in_item.operation == OP_LOAD_REQ) begin
                mem_req[wr_addr] <= amt;
            end
        end
        r_alloc_q <= mem_alloc[{r_sp, r_sr}];
        r_req_q   <= mem_req[{r_sp, r_sr}];
    end

    // Payload registers of the compare stage
    always_ff @(posedge i_clk) begin
        r_rd_p <= r_sp;
        r_rd_r <= r_sr;
        if (r_rd_vld) begin
            r_ok          <= ok_now;
            r_tmp[r_rd_r] <= sat;
        end
        if (r_state == ST_EMIT && out_free) begin
            r_out.process_id  <= 3'(r_emit_p);
            r_out.deadlocked  <= !r_fin[r_emit_p];
            r_out.last_result <= (r_emit_p == PW'(NUM_PROCESSES - 1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_sp      <= '0;
            r_sr      <= '0;
            r_rd_vld  <= 1'b0;
            r_changed <= 1'b0;
            r_fin     <= '0;
            r_emit_p  <= '0;
            r_out_vld <= 1'b0;
            for (int i = 0; i < NUM_RESOURCES; i++) begin
                r_avail[i] <= '0;
                r_work[i]  <= '0;
            end
        end else begin
            r_state  <= n_state;
            r_rd_vld <= (r_state == ST_SCAN);

            // Load available vector
            if (in_acc && ri_ok && (i_in_item.operation == OP_LOAD_AVAIL)) begin
                r_avail[ri_idx] <= amt;
            end

            // Advance the issue counters row by row
            if (r_state == ST_SCAN) begin
                if (r_sr == RW'(NUM_RESOURCES - 1)) begin
                    r_sr <= '0;
                    r_sp <= (r_sp == PW'(NUM_PROCESSES - 1)) ? '0 : r_sp + 1'b1;
                end else begin
                    r_sr <= r_sr + 1'b1;
                end
            end

            if (commit) begin
                r_fin[r_rd_p] <= 1'b1;
                for (int i = 0; i < NUM_RESOURCES; i++) begin
                    r_work[i] <= (RW'(i) == r_rd_r) ? sat : r_tmp[i];
                end
            end

            // Start a run: copy available into work, drop all finished flags
            if (r_state == ST_IDLE && in_acc && is_run) begin
                r_sp      <= '0;
                r_sr      <= '0;
                r_changed <= 1'b0;
                r_fin     <= '0;
                for (int i = 0; i < NUM_RESOURCES; i++) begin
                    r_work[i] <= WB'(r_avail[i]);
                end
            end else if (restart) begin
                r_sp      <= '0;
                r_sr      <= '0;
                r_changed <= 1'b0;
            end else if (commit) begin
                r_changed <= 1'b1;
            end

            if (r_state == ST_SETTLE) begin
                r_emit_p <= '0;
            end else if (r_state == ST_EMIT && out_free) begin
                r_emit_p <= r_emit_p + 1'b1;
            end

            // Output register: hold under stall, refill or drop when taken
            if (r_state == ST_EMIT && out_free) begin
                r_out_vld <= 1'b1;
            end else if (out_free) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_run_starts_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE && in_acc && is_run) |=> (r_state == ST_SCAN))
        else $error("run transaction did not start a scan");

    a_busy_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN || r_state == ST_SETTLE) |-> o_in_stall)
        else $error("input accepted during a scan");

    a_flags_only_rise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_vld |=> (($past(r_fin) & ~r_fin) == '0))
        else $error("finished flag dropped during a run");

    a_last_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT && out_free && r_emit_p == PW'(NUM_PROCESSES - 1))
        |=> (r_state == ST_IDLE && o_out_valid && o_out_item.last_result))
        else $error("final result not marked or run not closed");

endmodule

>>> sim/resource_deadlock_detector_test.sv
// Self-checking testbench for resource_deadlock_detector: queued loads and runs,
// a built-in predictor of the detection passes, random idling on both channels.
// Depends on rdd_pkg and the resource_deadlock_detector RTL.
`timescale 1ns / 1ps

module resource_deadlock_detector_test;
    import rdd_pkg::*;

    localparam int NUM_PROC     = 8;
    localparam int NUM_RES      = 4;
    localparam int AMT_BITS     = 8;
    // A run is at most (NUM_PROC + 1) passes over the tables plus the result
    // burst; nothing moves on either channel meanwhile.
    localparam int RUN_CYCLES   = (NUM_PROC + 1) * (NUM_PROC * NUM_RES + 1) + NUM_PROC;
    localparam int STALL_LIMIT  = 20 * RUN_CYCLES;
    localparam int SETTLE       = RUN_CYCLES + 100;
    localparam int PHASE_ITEMS  = 28;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      o_in_stall;
    t_in_item  in_item = '0;
    logic      o_out_valid;
    logic      out_stall = 1'b0;
    t_out_item o_out_item;

    resource_deadlock_detector #(
        .NUM_PROCESSES(NUM_PROC),
        .NUM_RESOURCES(NUM_RES),
        .AMOUNT_BITS  (AMT_BITS)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (o_in_stall),
        .i_in_item  (in_item),
        .o_out_valid(o_out_valid),
        .i_out_stall(out_stall),
        .o_out_item (o_out_item)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Transactions waiting to be driven, and verdicts waiting to come out
    t_in_item  pending_loads[$];
    t_out_item deadlock_verdicts[$];

    // Mirror of the block's vectors and tables
    logic [AMT_BITS-1:0] avail_mirror[NUM_RES];
    logic [AMT_BITS-1:0] alloc_mirror[NUM_PROC][NUM_RES];
    logic [AMT_BITS-1:0] req_mirror[NUM_PROC][NUM_RES];

    int unsigned sender_idle_pct = 0;
    int unsigned receiver_stall_pct = 0;
    int unsigned queued_count = 0;
    int unsigned mismatches = 0;
    int unsigned quiet_cycles = 0;

    // Run the detection passes on the mirror and queue one verdict per process
    function automatic void predict_detection();
        logic [WORK_BITS-1:0] work[NUM_RES];
        bit                   done[NUM_PROC];
        bit                   changed;
        bit                   ready;
        int unsigned          sum;
        t_out_item            verdict;
        for (int r = 0; r < NUM_RES; r++) work[r] = avail_mirror[r];
        for (int p = 0; p < NUM_PROC; p++) done[p] = 1'b0;
        changed = 1'b1;
        // Sweep in process order until a whole sweep finishes nobody new
        while (changed) begin
            changed = 1'b0;
            for (int p = 0; p < NUM_PROC; p++) begin
                if (!done[p]) begin
                    ready = 1'b1;
                    for (int r = 0; r < NUM_RES; r++)
                        if (req_mirror[p][r] > work[r]) ready = 1'b0;
                    if (ready) begin
                        // Release the row, saturating each work entry
                        for (int r = 0; r < NUM_RES; r++) begin
                            sum = work[r] + alloc_mirror[p][r];
                            work[r] = (sum > WORK_MAX) ? WORK_BITS'(WORK_MAX)
                                                       : WORK_BITS'(sum);
                        end
                        done[p] = 1'b1;
                        changed = 1'b1;
                    end
                end
            end
        end
        for (int p = 0; p < NUM_PROC; p++) begin
            verdict.process_id  = 3'(p);
            verdict.deadlocked  = !done[p];
            verdict.last_result = (p == NUM_PROC - 1);
            deadlock_verdicts.push_back(verdict);
        end
    endfunction

    // Update the mirror for one accepted transaction
    function automatic void absorb_transaction(input t_in_item it);
        logic [AMT_BITS-1:0] amt;
        amt = it.amount[AMT_BITS-1:0];
        case (it.operation)
            OP_RUN: begin
                predict_detection();
            end
            OP_LOAD_AVAIL: begin
                if (it.resource_index < NUM_RES) avail_mirror[it.resource_index] = amt;
            end
            OP_LOAD_ALLOC: begin
                if (it.resource_index < NUM_RES && it.process_index < NUM_PROC)
                    alloc_mirror[it.process_index][it.resource_index] = amt;
            end
            default: begin
                if (it.resource_index < NUM_RES && it.process_index < NUM_PROC)
                    req_mirror[it.process_index][it.resource_index] = amt;
            end
        endcase
    endfunction

    task automatic queue_item(input logic [1:0] op, input logic [2:0] pidx,
                              input logic [1:0] ridx, input logic [7:0] amt);
        t_in_item it;
        it.operation      = op;
        it.process_index  = pidx;
        it.resource_index = ridx;
        it.amount         = amt;
        pending_loads.push_back(it);
        queued_count++;
    endtask

    task automatic queue_run();
        queue_item(OP_RUN, 3'($urandom), 2'($urandom), 8'($urandom));
    endtask

    // One random episode: mostly a fresh available vector, a few table edits
    // and a run; sometimes raw full-range loads or a repeated run.
    task automatic queue_random_episode();
        int unsigned kind;
        int unsigned edits;
        kind = $urandom_range(0, 9);
        if (kind < 8) begin
            for (int r = 0; r < NUM_RES; r++)
                queue_item(OP_LOAD_AVAIL, 3'($urandom), 2'(r), 8'($urandom_range(0, 6)));
            edits = $urandom_range(2, 8);
            repeat (edits)
                queue_item($urandom_range(0, 1) ? OP_LOAD_ALLOC : OP_LOAD_REQ,
                           3'($urandom), 2'($urandom),
                           8'($urandom_range(0, (kind < 4) ? 4 : 10)));
            queue_run();
        end else if (kind == 8) begin
            repeat (3)
                queue_item(2'($urandom_range(OP_LOAD_AVAIL, OP_LOAD_REQ)),
                           3'($urandom), 2'($urandom), 8'($urandom));
        end else begin
            queue_run();
        end
    endtask

    // Hold the thread until the driver is empty and every verdict has arrived
    task automatic drain();
        while (pending_loads.size() != 0 || in_valid || deadlock_verdicts.size() != 0)
            @(posedge i_clk);
    endtask

    // Driver: advance to the next transaction once the current one is taken
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !o_in_stall) absorb_transaction(in_item);
            if (!in_valid || !o_in_stall) begin
                if (pending_loads.size() != 0 &&
                    $urandom_range(0, 99) >= sender_idle_pct) begin
                    in_item  <= pending_loads.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver back-pressure
    always @(posedge i_clk) begin
        out_stall <= i_rst_n && ($urandom_range(0, 99) < receiver_stall_pct);
    end

    // Monitor: compare each accepted verdict with the oldest expectation
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && !out_stall) begin
            if (deadlock_verdicts.size() == 0) begin
                $error("unexpected verdict: process_id %0d deadlocked %0d last_result %0d",
                       o_out_item.process_id, o_out_item.deadlocked,
                       o_out_item.last_result);
                mismatches++;
            end else begin
                want = deadlock_verdicts.pop_front();
                if (o_out_item.process_id !== want.process_id) begin
                    $error("process_id: expected %0d, got %0d",
                           want.process_id, o_out_item.process_id);
                    mismatches++;
                end
                if (o_out_item.deadlocked !== want.deadlocked) begin
                    $error("deadlocked: expected %0d, got %0d",
                           want.deadlocked, o_out_item.deadlocked);
                    mismatches++;
                end
                if (o_out_item.last_result !== want.last_result) begin
                    $error("last_result: expected %0d, got %0d",
                           want.last_result, o_out_item.last_result);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog: count cycles with no transaction on either channel
    always @(posedge i_clk) begin
        if ((in_valid && !o_in_stall) || (o_out_valid && !out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAIL resource_deadlock_detector");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        for (int r = 0; r < NUM_RES; r++) avail_mirror[r] = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part, no idling. Write every table entry first so that no
        // run ever reads an entry that was never loaded.
        for (int p = 0; p < NUM_PROC; p++)
            for (int r = 0; r < NUM_RES; r++) begin
                queue_item(OP_LOAD_ALLOC, 3'(p), 2'(r), 8'd0);
                queue_item(OP_LOAD_REQ, 3'(p), 2'(r), 8'd0);
            end
        // Empty tables and nothing available: every process finishes
        queue_run();
        // Circular wait between processes 0 and 1
        queue_item(OP_LOAD_ALLOC, 3'd0, 2'd0, 8'd1);
        queue_item(OP_LOAD_REQ,   3'd0, 2'd1, 8'd1);
        queue_item(OP_LOAD_ALLOC, 3'd1, 2'd1, 8'd1);
        queue_item(OP_LOAD_REQ,   3'd1, 2'd0, 8'd1);
        queue_run();
        // One spare instance breaks the cycle, but only on a second sweep
        queue_item(OP_LOAD_AVAIL, 3'd7, 2'd0, 8'd1);
        queue_run();
        // Request equal to the full-scale available count still finishes
        queue_item(OP_LOAD_REQ,   3'd7, 2'd3, 8'd255);
        queue_item(OP_LOAD_AVAIL, 3'd0, 2'd3, 8'd255);
        queue_run();
        // One short of it deadlocks
        queue_item(OP_LOAD_AVAIL, 3'd5, 2'd3, 8'd254);
        queue_run();
        // A full-scale release lifts work above the amount width
        queue_item(OP_LOAD_ALLOC, 3'd2, 2'd3, 8'd255);
        queue_run();
        drain();

        // Random part in four idling phases; drain between phases
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
                1: begin sender_idle_pct = 47; receiver_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  receiver_stall_pct = 47; end
                default: begin sender_idle_pct = 6; receiver_stall_pct = 6; end
            endcase
            queued_count = 0;
            while (queued_count < PHASE_ITEMS) queue_random_episode();
            queue_run();
            drain();
        end

        // Let any stray verdict show up before deciding
        repeat (SETTLE) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("PASS resource_deadlock_detector");
        end else begin
            $display("FAIL resource_deadlock_detector");
        end
        $finish;
    end

endmodule

>>> resource_deadlock_detector.f
rtl/core/rdd_pkg.sv
rtl/core/resource_deadlock_detector.sv
sim/resource_deadlock_detector_test.sv
